### rtl/core/btac_pkg.sv
package btac_pkg;

   typedef logic [31:0] argb_type;
   typedef logic [23:0] rgb_type;
   typedef logic [7:0]  chan_type;
   typedef logic [7:0]  frac_type;
   typedef logic [2:0]  state_code_type;

   // Tint modes written into the control register. Codes above DISABLED act as NORMAL.
   typedef enum logic [2:0] {
      TINT_NORMAL   = 3'd0,
      TINT_HOVER    = 3'd1,
      TINT_PRESSED  = 3'd2,
      TINT_ACTIVE   = 3'd3,
      TINT_DISABLED = 3'd4
   } tint_type;

   // Channel slots inside an ARGB word, blue lowest.
   localparam int unsigned CH_B = 0;
   localparam int unsigned CH_G = 1;
   localparam int unsigned CH_R = 2;
   localparam int unsigned CH_A = 3;
   localparam int unsigned NUM_CH = 4;
   localparam int unsigned NUM_COLOR = 3;

   localparam logic [8:0]  HOVER_BOOST   = 9'd28;
   localparam logic [7:0]  PRESSED_GAIN  = 8'd200;
   localparam logic [7:0]  ACTIVE_GAIN   = 8'd220;
   localparam logic [15:0] ACTIVE_MIX_R  = 16'(56 * 35);
   localparam logic [15:0] ACTIVE_MIX_G  = 16'(189 * 35);
   localparam logic [15:0] ACTIVE_MIX_B  = 16'(248 * 35);
   localparam logic [7:0]  LUM_WEIGHT_R  = 8'd77;
   localparam logic [7:0]  LUM_WEIGHT_G  = 8'd150;
   localparam logic [7:0]  LUM_WEIGHT_B  = 8'd29;
   localparam chan_type    SKIP_BELOW    = 8'd4;
   localparam chan_type    OPAQUE_MIN    = 8'd250;
   localparam chan_type    CHAN_MAX      = 8'd255;
   localparam chan_type    ALPHA_OPAQUE  = 8'hFF;

   // One step of the bilinear filter: (p*(256-w) + q*w) >> 8.
   function automatic chan_type lerp8(input chan_type p, input chan_type q, input frac_type w);
      logic [16:0] acc;
      acc = 17'(p) * (17'd256 - 17'(w)) + 17'(q) * 17'(w);
      return acc[15:8];
   endfunction

   // Truncating division by 255, exact for every value below 65535.
   function automatic logic [8:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = 17'(x) + 17'(x[15:8]) + 17'd1;
      return t[16:8];
   endfunction

endpackage

### rtl/core/btac_req_if.sv
interface btac_req_if;
   import btac_pkg::*;

   logic     valid;
   logic     ready;
   argb_type texel_top_left;
   argb_type texel_top_right;
   argb_type texel_bottom_left;
   argb_type texel_bottom_right;
   frac_type frac_x;
   frac_type frac_y;
   rgb_type  dest_rgb;

   modport source (
      output valid, texel_top_left, texel_top_right, texel_bottom_left,
             texel_bottom_right, frac_x, frac_y, dest_rgb,
      input  ready
   );

   modport sink (
      input  valid, texel_top_left, texel_top_right, texel_bottom_left,
             texel_bottom_right, frac_x, frac_y, dest_rgb,
      output ready
   );
endinterface

### rtl/core/btac_rsp_if.sv
interface btac_rsp_if;
   import btac_pkg::*;

   logic     valid;
   logic     ready;
   logic     write_enable;
   argb_type out_pixel;

   modport source (
      output valid, write_enable, out_pixel,
      input  ready
   );

   modport sink (
      input  valid, write_enable, out_pixel,
      output ready
   );
endinterface

### rtl/core/bilinear_tint_alpha_compositor.sv
// Bilinear tint and alpha compositor. Each transfer on the req channel carries the four
// ARGB8888 texels around a sample point, 8-bit horizontal and vertical weights and the
// current RGB888 destination pixel; the block returns one transfer on the rsp channel per
// request, in order, with write_enable low (and a zero pixel) when the filtered alpha is
// below 4, and otherwise an opaque ARGB pixel that is the tinted texel color either written
// as is (alpha of 250 or more) or blended over the destination by alpha/255. The tint mode
// comes from the 3-bit register written through csr_write_enable/csr_write_data: 0 normal,
// 1 hover, 2 pressed, 3 active, 4 disabled, and 5 to 7 behave as normal. Only change it
// while no request is in flight. The datapath is a six-stage pipeline: horizontal filter,
// vertical filter, tint products, tint divide, blend products, and the output register with
// the final divide by 255. A new request is taken every clock while the pipeline advances,
// and the whole pipeline holds while the output register keeps a result that the sink has
// not taken, so backpressure stalls the request side directly.
module bilinear_tint_alpha_compositor (
   input  logic                      clock,
   input  logic                      reset,
   btac_req_if.sink                  req_bus,
   btac_rsp_if.source                rsp_bus,
   input  logic                      csr_write_enable,
   input  btac_pkg::state_code_type  csr_write_data
);
   import btac_pkg::*;

   // Pipeline advance: every stage moves when the output register is free or being taken.
   logic advance;

   // Control register.
   state_code_type tint_state_ff;

   // User changes tint mode only on an empty pipeline (not enforced); stage 4 reads it live.
   state_code_type s3_state_code;

   // Stage 1: horizontal filter results.
   logic     s1_valid_ff,  s1_valid_in;
   chan_type s1_top_ff [NUM_CH];
   chan_type s1_bot_ff [NUM_CH];
   chan_type s1_top_in [NUM_CH];
   chan_type s1_bot_in [NUM_CH];
   frac_type s1_frac_y_ff;
   rgb_type  s1_dest_ff;

   // Stage 2: filtered ARGB.
   logic     s2_valid_ff;
   chan_type s2_chan_ff [NUM_CH];
   chan_type s2_chan_in [NUM_CH];
   rgb_type  s2_dest_ff;

   // Stage 3: tint products for every mode, the selection happens in stage 4.
   logic        s3_valid_ff;
   logic [8:0]  s3_hover_ff   [NUM_COLOR];
   logic [15:0] s3_pressed_ff [NUM_COLOR];
   logic [15:0] s3_active_ff  [NUM_COLOR];
   logic [8:0]  s3_hover_in   [NUM_COLOR];
   logic [15:0] s3_pressed_in [NUM_COLOR];
   logic [15:0] s3_active_in  [NUM_COLOR];
   chan_type    s3_color_ff   [NUM_COLOR];
   chan_type    s3_lum_ff,   s3_lum_in;
   chan_type    s3_alpha_ff;
   logic        s3_skip_ff;
   rgb_type     s3_dest_ff;

   // Stage 4: tinted color and effective alpha.
   logic     s4_valid_ff;
   chan_type s4_color_ff [NUM_COLOR];
   chan_type s4_color_in [NUM_COLOR];
   chan_type s4_alpha_ff, s4_alpha_in;
   logic     s4_skip_ff;
   rgb_type  s4_dest_ff;

   // Stage 5: blend sums before the divide by 255.
   logic        s5_valid_ff;
   logic [15:0] s5_blend_ff [NUM_COLOR];
   logic [15:0] s5_blend_in [NUM_COLOR];
   chan_type    s5_color_ff [NUM_COLOR];
   logic        s5_opaque_ff, s5_opaque_in;
   logic        s5_skip_ff;

   // Stage 6: output register.
   logic     rsp_valid_ff;
   logic     rsp_write_ff, rsp_write_in;
   argb_type rsp_pixel_ff, rsp_pixel_in;

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;
   assign s1_valid_in   = req_bus.valid;
   assign s3_state_code = tint_state_ff;

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.write_enable = rsp_write_ff;
   assign rsp_bus.out_pixel    = rsp_pixel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tint_state_ff <= state_code_type'(TINT_NORMAL);
      end else if (csr_write_enable) begin
         tint_state_ff <= csr_write_data;
      end
   end

   // Valid bits travel with the data and are the only pipeline state cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         rsp_valid_ff <= s5_valid_ff;
      end
   end

   // Stage 1: filter the top and bottom texel rows along x, one lerp per channel and row.
   always_comb begin
      for (int unsigned ch = 0; ch < NUM_CH; ch++) begin
         s1_top_in[ch] = lerp8(req_bus.texel_top_left[8*ch +: 8],
                               req_bus.texel_top_right[8*ch +: 8], req_bus.frac_x);
         s1_bot_in[ch] = lerp8(req_bus.texel_bottom_left[8*ch +: 8],
                               req_bus.texel_bottom_right[8*ch +: 8], req_bus.frac_x);
      end
   end

   // Stage 2: filter the two row results along y.
   always_comb begin
      for (int unsigned ch = 0; ch < NUM_CH; ch++) begin
         s2_chan_in[ch] = lerp8(s1_top_ff[ch], s1_bot_ff[ch], s1_frac_y_ff);
      end
   end

   // Stage 3: raw products of every tint mode, plus the luminance used when disabled.
   always_comb begin
      logic [16:0] lum_sum;
      for (int unsigned ch = 0; ch < NUM_COLOR; ch++) begin
         s3_hover_in[ch]   = 9'(s2_chan_ff[ch]) + HOVER_BOOST;
         s3_pressed_in[ch] = 16'(s2_chan_ff[ch]) * 16'(PRESSED_GAIN);
         s3_active_in[ch]  = 16'(s2_chan_ff[ch]) * 16'(ACTIVE_GAIN);
      end
      s3_active_in[CH_R] = s3_active_in[CH_R] + ACTIVE_MIX_R;
      s3_active_in[CH_G] = s3_active_in[CH_G] + ACTIVE_MIX_G;
      s3_active_in[CH_B] = s3_active_in[CH_B] + ACTIVE_MIX_B;
      lum_sum = 17'(s2_chan_ff[CH_R]) * 17'(LUM_WEIGHT_R)
              + 17'(s2_chan_ff[CH_G]) * 17'(LUM_WEIGHT_G)
              + 17'(s2_chan_ff[CH_B]) * 17'(LUM_WEIGHT_B);
      s3_lum_in = lum_sum[15:8];
   end

   // Stage 4: pick the tint mode, finish its divide and saturation, halve alpha if disabled.
   always_comb begin
      logic [8:0] quot;
      quot        = '0;
      s4_alpha_in = s3_alpha_ff;
      for (int unsigned ch = 0; ch < NUM_COLOR; ch++) begin
         s4_color_in[ch] = s3_color_ff[ch];
      end
      case (s3_state_code)
         TINT_HOVER: begin
            for (int unsigned ch = 0; ch < NUM_COLOR; ch++) begin
               s4_color_in[ch] = s3_hover_ff[ch][8] ? CHAN_MAX : s3_hover_ff[ch][7:0];
            end
         end
         TINT_PRESSED: begin
            for (int unsigned ch = 0; ch < NUM_COLOR; ch++) begin
               quot            = div255(s3_pressed_ff[ch]);
               s4_color_in[ch] = quot[7:0];
            end
         end
         TINT_ACTIVE: begin
            for (int unsigned ch = 0; ch < NUM_COLOR; ch++) begin
               quot            = div255(s3_active_ff[ch]);
               s4_color_in[ch] = quot[8] ? CHAN_MAX : quot[7:0];
            end
         end
         TINT_DISABLED: begin
            for (int unsigned ch = 0; ch < NUM_COLOR; ch++) begin
               s4_color_in[ch] = s3_lum_ff;
            end
            s4_alpha_in = s3_alpha_ff >> 1;
         end
         default: begin
         end
      endcase
   end

   // Stage 5: blend products against the destination; the opacity test uses the tinted alpha.
   always_comb begin
      chan_type dest_ch;
      s5_opaque_in = (s4_alpha_ff >= OPAQUE_MIN);
      for (int unsigned ch = 0; ch < NUM_COLOR; ch++) begin
         dest_ch         = s4_dest_ff[8*ch +: 8];
         s5_blend_in[ch] = 16'(s4_color_ff[ch]) * 16'(s4_alpha_ff)
                         + 16'(dest_ch) * 16'(CHAN_MAX - s4_alpha_ff);
      end
   end

   // Stage 6: final divide and packing; a skipped pixel reports a zero word.
   always_comb begin
      logic [8:0] quot;
      quot         = '0;
      rsp_write_in = !s5_skip_ff;
      rsp_pixel_in = '0;
      if (!s5_skip_ff) begin
         rsp_pixel_in[8*CH_A +: 8] = ALPHA_OPAQUE;
         for (int unsigned ch = 0; ch < NUM_COLOR; ch++) begin
            quot = div255(s5_blend_ff[ch]);
            rsp_pixel_in[8*ch +: 8] = s5_opaque_ff ? s5_color_ff[ch] : quot[7:0];
         end
      end
   end

   // Datapath registers, all held while the pipeline stalls.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_top_ff    <= s1_top_in;
         s1_bot_ff    <= s1_bot_in;
         s1_frac_y_ff <= req_bus.frac_y;
         s1_dest_ff   <= req_bus.dest_rgb;

         s2_chan_ff   <= s2_chan_in;
         s2_dest_ff   <= s1_dest_ff;

         s3_hover_ff   <= s3_hover_in;
         s3_pressed_ff <= s3_pressed_in;
         s3_active_ff  <= s3_active_in;
         for (int unsigned ch = 0; ch < NUM_COLOR; ch++) begin
            s3_color_ff[ch] <= s2_chan_ff[ch];
         end
         s3_lum_ff    <= s3_lum_in;
         s3_alpha_ff  <= s2_chan_ff[CH_A];
         s3_skip_ff   <= (s2_chan_ff[CH_A] < SKIP_BELOW);
         s3_dest_ff   <= s2_dest_ff;

         s4_color_ff  <= s4_color_in;
         s4_alpha_ff  <= s4_alpha_in;
         s4_skip_ff   <= s3_skip_ff;
         s4_dest_ff   <= s3_dest_ff;

         s5_blend_ff  <= s5_blend_in;
         s5_color_ff  <= s4_color_ff;
         s5_opaque_ff <= s5_opaque_in;
         s5_skip_ff   <= s4_skip_ff;

         rsp_write_ff <= rsp_write_in;
         rsp_pixel_ff <= rsp_pixel_in;
      end
   end

endmodule
